>>> hw/rtl/ipst_pkg.sv
`timescale 1ns / 1ps

package ipst_pkg;

    localparam int SETS     = 32768;
    localparam int WAYS     = 4;
    localparam int KEY_W    = 64;
    localparam int DEPTH_W  = 6;
    localparam int OP_W     = 2;
    localparam int SET_W    = $clog2(SETS);
    localparam int ROW_W    = WAYS * KEY_W;
    localparam int S_DATA_W = ((KEY_W + DEPTH_W + 7) / 8) * 8;
    localparam int M_DATA_W = 8;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [DEPTH_W-1:0] MIN_DEPTH_RST = DEPTH_W'(3);

    localparam logic [OP_W-1:0] OP_QUERY  = 2'd0;
    localparam logic [OP_W-1:0] OP_START  = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

    localparam logic REG_MIN_DEPTH = 1'b0;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [ROW_W-1:0] t_row;

    typedef struct packed {
        logic hit;
        logic write;
    } t_upd_res;

endpackage

>>> hw/rtl/ipst_ram.sv
`timescale 1ns / 1ps

module ipst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/ipst_update.sv
`timescale 1ns / 1ps

module ipst_update
    import ipst_pkg::*;
(
    input  logic            i_active,
    input  logic [OP_W-1:0] i_op,
    input  t_key            i_key,
    input  t_row            i_row,
    output t_row            o_row,
    output t_upd_res        o_res
);

    logic [WAYS-1:0] hit;
    logic [WAYS-1:0] empty;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            hit[w]   = (i_row[w*KEY_W +: KEY_W] == i_key);
            empty[w] = (i_row[w*KEY_W +: KEY_W] == '0);
        end
    end

    always_comb begin
        logic done;
        done      = 1'b0;
        o_row     = i_row;
        o_res.hit = 1'b0;
        o_res.write = 1'b0;
        if (i_active) begin
            unique case (i_op)
                OP_QUERY: begin
                    o_res.hit = |hit;
                end
                OP_START: begin
                    o_res.write = 1'b1;
                    for (int w = 0; w < WAYS; w++) begin
                        if (!done) begin
                            if (empty[w]) begin
                                o_row[w*KEY_W +: KEY_W] = i_key;
                                done = 1'b1;
                            end else if (hit[w]) begin
                                done = 1'b1;
                            end
                        end
                    end
                    if (!done) begin
                        o_row[KEY_W-1:0] = i_key;
                    end
                end
                OP_FINISH: begin
                    o_res.write = 1'b1;
                    for (int w = 0; w < WAYS; w++) begin
                        if (hit[w]) begin
                            o_row[w*KEY_W +: KEY_W] = '0;
                        end
                    end
                end
                default: begin
                    o_res.write = 1'b0;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/in_progress_search_table.sv
`timescale 1ns / 1ps

// Set-associative table of 64-bit keys marking work items in progress. Each request
// transaction carries an operation in s_tuser (query, start, finish) and the key and depth
// in s_tdata; exactly one result transaction with the in-progress bit follows. A request
// reads its set from the single table memory on acceptance; in the compare state the ways
// are compared and the set written back. No request is accepted until the compare state
// has loaded its result, which waits for a free output register. After reset the table
// is cleared one set per cycle; no request is accepted then, while configuration writes are.
module in_progress_search_table
    import ipst_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Slave side: tdata holds key [63:0], depth [69:64], zero fill [71:70].
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    // tuser holds op [1:0].
    input  logic [OP_W-1:0]     s_tuser,
    // Master side: tdata holds in_progress [0], zero fill [7:1].
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_COMP  = 2'd2;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [SET_W-1:0]   r_clr_addr;
    logic [DEPTH_W-1:0] r_min_depth;
    logic [OP_W-1:0]    r_op;
    t_key               r_key;
    logic [DEPTH_W-1:0] r_depth;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               r_out_bit;

    logic               in_fire;
    logic               load_out;
    logic               ram_we;
    logic [SET_W-1:0]   ram_waddr;
    t_row               ram_wdata;
    t_row               ram_rdata;
    t_row               upd_row;
    t_upd_res           upd_res;
    t_key               in_key;
    logic [DEPTH_W-1:0] in_depth;

    assign in_key   = s_tdata[KEY_W-1:0];
    assign in_depth = s_tdata[KEY_W +: DEPTH_W];
    assign s_tready = (r_state == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign load_out = (r_state == ST_COMP) && (!r_out_valid || m_tready);

    ipst_update u_update (
        .i_active (r_depth >= r_min_depth),
        .i_op     (r_op),
        .i_key    (r_key),
        .i_row    (ram_rdata),
        .o_row    (upd_row),
        .o_res    (upd_res)
    );

    always_comb begin
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = load_out && upd_res.write;
            ram_waddr = r_key[SET_W-1:0];
            ram_wdata = upd_row;
        end
    end

    ipst_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_fire),
        .i_raddr (in_key[SET_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == SET_W'(SETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_COMP;
                end
            end
            ST_COMP: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_min_depth <= MIN_DEPTH_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + SET_W'(1);
            end
            if (psel && penable && pwrite && pready && (paddr[2] == REG_MIN_DEPTH)) begin
                r_min_depth <= pwdata[DEPTH_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op    <= s_tuser;
            r_key   <= in_key;
            r_depth <= in_depth;
        end
        if (load_out) begin
            r_out_bit <= upd_res.hit;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {(M_DATA_W - 1)'(0), r_out_bit};
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_MIN_DEPTH) ? {(APB_DW - DEPTH_W)'(0), r_min_depth}
                                                  : '0;

endmodule

>>> dv/tb_in_progress_search_table.sv
`timescale 1ns / 1ps

module tb_in_progress_search_table;
    import ipst_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 300;
    localparam int PHASES      = 6;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        t_key               key;
        logic [DEPTH_W-1:0] depth;
    } t_request;

    typedef struct packed {
        logic     in_progress;
        t_request req;
    } t_answer;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0]     s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [APB_AW-1:0]   paddr   = '0;
    logic [APB_DW-1:0]   pwdata  = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    in_progress_search_table u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Mirror of the key table and of the depth threshold.
    bit [KEY_W-1:0]     mirror_keys [SETS][WAYS];
    logic [DEPTH_W-1:0] mirror_min_depth = MIN_DEPTH_RST;

    t_request    pending_q [$];
    t_answer     answer_q [$];
    t_request    in_flight;
    int unsigned send_gap    = 0;
    int unsigned stall_left  = 0;
    bit          no_idle     = 1'b0;
    int unsigned hot_sets [6];

    int unsigned mismatches   = 0;
    int unsigned accepted     = 0;
    int unsigned checked      = 0;
    int unsigned query_hits   = 0;
    int unsigned query_misses = 0;
    int unsigned overwrites   = 0;
    int unsigned ignored      = 0;
    int unsigned settings     = 0;

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 100) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle) begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(3, 1);
        end
        if (r < 98) begin
            return $urandom_range(10, 4);
        end
        return $urandom_range(60, 20);
    endfunction

    // Applies one accepted request to the mirror and returns the expected in-progress bit.
    function automatic logic apply_request(input t_request r);
        int unsigned set_idx;
        logic        hit;
        bit          done;
        set_idx = int'(r.key[SET_W-1:0]);
        hit = 1'b0;
        done = 1'b0;
        if (r.depth < mirror_min_depth) begin
            ignored++;
            return 1'b0;
        end
        case (r.op)
            OP_QUERY: begin
                for (int w = 0; w < WAYS; w++) begin
                    if (mirror_keys[set_idx][w] == r.key) begin
                        hit = 1'b1;
                    end
                end
                if (hit) begin
                    query_hits++;
                end else begin
                    query_misses++;
                end
            end
            OP_START: begin
                for (int w = 0; w < WAYS; w++) begin
                    if (!done) begin
                        if (mirror_keys[set_idx][w] == '0) begin
                            mirror_keys[set_idx][w] = r.key;
                            done = 1'b1;
                        end else if (mirror_keys[set_idx][w] == r.key) begin
                            done = 1'b1;
                        end
                    end
                end
                if (!done) begin
                    mirror_keys[set_idx][0] = r.key;
                    overwrites++;
                end
            end
            OP_FINISH: begin
                for (int w = 0; w < WAYS; w++) begin
                    if (mirror_keys[set_idx][w] == r.key) begin
                        mirror_keys[set_idx][w] = '0;
                    end
                end
            end
            default: begin
                ignored++;
            end
        endcase
        return hit;
    endfunction

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                answer_q.push_back('{in_progress: apply_request(in_flight), req: in_flight});
                accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    in_flight = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_DATA_W - KEY_W - DEPTH_W){1'b0}}, in_flight.depth,
                                 in_flight.key};
                    s_tuser  <= in_flight.op;
                    send_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        t_answer a;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (answer_q.size() == 0) begin
                    report_mismatch($sformatf("result transaction %b with none outstanding",
                                              m_tdata[0]));
                end else begin
                    a = answer_q.pop_front();
                    checked++;
                    if (m_tdata[0] !== a.in_progress) begin
                        report_mismatch($sformatf(
                            "op %0d key %h depth %0d: in_progress %b, expected %b",
                            a.req.op, a.req.key, a.req.depth, m_tdata[0], a.in_progress));
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    task automatic write_min_depth(input logic [DEPTH_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({REG_MIN_DEPTH, 2'b00});
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mirror_min_depth = value;
        settings++;
    endtask

    task automatic queue_req(input logic [OP_W-1:0] op, input t_key key,
                             input logic [DEPTH_W-1:0] depth);
        pending_q.push_back('{op: op, key: key, depth: depth});
    endtask

    task automatic drain();
        while (!(pending_q.size() == 0 && !s_tvalid && answer_q.size() == 0)) begin
            @(negedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_key set_key(input int unsigned set_idx, input logic [48:0] tag);
        return {tag, SET_W'(set_idx)};
    endfunction

    function automatic t_key random_key();
        int unsigned r;
        logic [48:0] tag;
        r = $urandom_range(99);
        if (r < 3) begin
            return '0;
        end
        if (r < 20) begin
            return {$urandom, $urandom};
        end
        if (r < 28) begin
            tag = 49'({$urandom, $urandom});
        end else begin
            tag = 49'($urandom_range(6, 1));
        end
        return set_key(hot_sets[$urandom_range(5)], tag);
    endfunction

    function automatic logic [OP_W-1:0] random_op();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 35) begin
            return OP_QUERY;
        end
        if (r < 70) begin
            return OP_START;
        end
        if (r < 95) begin
            return OP_FINISH;
        end
        return OP_UNUSED;
    endfunction

    initial begin
        logic [DEPTH_W-1:0] threshold;
        logic [DEPTH_W-1:0] depth;
        hot_sets[0] = 0;
        hot_sets[1] = SETS - 1;
        for (int i = 2; i < 6; i++) begin
            hot_sets[i] = $urandom_range(SETS - 2, 1);
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests at the reset threshold.
        write_min_depth(DEPTH_W'(3));
        queue_req(OP_QUERY,  set_key(5, 1), 6'd63);
        queue_req(OP_START,  set_key(5, 1), 6'd3);
        queue_req(OP_QUERY,  set_key(5, 1), 6'd40);
        queue_req(OP_START,  set_key(5, 1), 6'd40);
        queue_req(OP_START,  set_key(5, 2), 6'd40);
        queue_req(OP_START,  set_key(5, 3), 6'd40);
        queue_req(OP_START,  set_key(5, 4), 6'd40);
        queue_req(OP_START,  set_key(5, 5), 6'd40);
        queue_req(OP_QUERY,  set_key(5, 1), 6'd40);
        queue_req(OP_QUERY,  set_key(5, 5), 6'd40);
        queue_req(OP_FINISH, set_key(5, 3), 6'd40);
        queue_req(OP_QUERY,  set_key(5, 3), 6'd40);
        queue_req(OP_START,  set_key(5, 1), 6'd40);
        queue_req(OP_START,  set_key(5, 6), 6'd2);
        queue_req(OP_QUERY,  set_key(5, 6), 6'd63);
        queue_req(OP_QUERY,  set_key(5, 5), 6'd0);
        queue_req(OP_UNUSED, set_key(5, 2), 6'd63);
        queue_req(OP_QUERY,  '0, 6'd63);
        queue_req(OP_START,  '0, 6'd63);
        queue_req(OP_FINISH, '0, 6'd63);
        queue_req(OP_START,  '1, 6'd63);
        queue_req(OP_QUERY,  '1, 6'd63);
        queue_req(OP_FINISH, '1, 6'd63);
        queue_req(OP_QUERY,  '1, 6'd63);
        for (int i = 1; i <= 4; i++) begin
            queue_req(OP_START, set_key(0, 49'(i)), 6'd10);
        end
        queue_req(OP_QUERY,  '0, 6'd10);
        queue_req(OP_START,  '0, 6'd10);
        queue_req(OP_QUERY,  '0, 6'd10);
        drain();

        // Random phases, each under its own threshold; every phase waits for all answers.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: threshold = 6'd0;
                1: threshold = 6'd63;
                2: threshold = 6'd3;
                4: threshold = 6'd1;
                default: threshold = DEPTH_W'($urandom_range(62, 2));
            endcase
            no_idle = (p == 2);
            write_min_depth(threshold);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(99) < 70) begin
                    depth = DEPTH_W'($urandom_range(63, threshold));
                end else begin
                    depth = DEPTH_W'($urandom_range(63));
                end
                queue_req(random_op(), random_key(), depth);
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        $display("Ran %0d requests (%0d answers checked) under %0d threshold settings.",
                 accepted, checked, settings);
        $display("Query hits %0d, misses %0d, way-0 evictions %0d, ignored requests %0d.",
                 query_hits, query_misses, overwrites, ignored);
        if (mismatches == 0 && answer_q.size() == 0) begin
            $display("PASS in_progress_search_table");
        end else begin
            $display("FAIL in_progress_search_table");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d answers outstanding.", answer_q.size());
        $display("FAIL in_progress_search_table");
        $finish;
    end

endmodule
